/* hw/rtl/pltr_pkg.sv */
// Shared types and constants of the piecewise linear time rescaler.
`default_nettype none
package pltr_pkg;

    localparam logic [23:0] SCALE_MAX   = 24'hFFFFFF;
    localparam logic [23:0] SCALE_ONE   = 24'h010000;
    localparam logic [23:0] THETA_RESET = 24'h010000;
    localparam logic [8:0]  BINS_RESET  = 9'd256;

    // Register index as decoded from the word address.
    localparam logic REG_THETA = 1'b0;
    localparam logic REG_BINS  = 1'b1;

    // Item functions.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MAP  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  bin_index;
        logic [31:0] upper_edge;
        logic [31:0] observed_len;
        logic [31:0] expected_len;
        logic [31:0] time_in;
        logic        passthru;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value_out;
        logic [23:0] scale_out;
        logic        saturated;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic ld_rd;
        logic ld_chk;
        logic div_step;
        logic map_init;
        logic scan;
        logic map_rd;
        logic map_lo;
        logic mul;
        logic add;
        logic samp_res;
        logic zero_res;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic passthru;
        logic oob;
        logic div_done;
        logic scan_done;
    } t_dp_sts;

endpackage
`default_nettype wire

/* hw/rtl/pltr_datapath.sv */
// Datapath of the rescaler: bin tables, divider, edge scan and scaled add.
`default_nettype none
module pltr_datapath #(
    parameter int BIN_DEPTH = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire pltr_pkg::t_dp_cmd i_cmd,
    output pltr_pkg::t_dp_sts   o_sts,
    input  wire pltr_pkg::t_in_item i_in_item,
    input  wire [23:0]          i_theta,
    input  wire [8:0]           i_bins_in_use,
    output pltr_pkg::t_out_item o_out_item
);
    localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int CW = $clog2(BIN_DEPTH + 1);

    logic [31:0] mem_old   [BIN_DEPTH];
    logic [31:0] mem_new   [BIN_DEPTH];
    logic [23:0] mem_scale [BIN_DEPTH];

    pltr_pkg::t_in_item  r_item;
    pltr_pkg::t_out_item r_res;
    pltr_pkg::t_out_item r_out;

    logic [31:0] r_rd_old, r_rd_new;
    logic [23:0] r_rd_scale;
    logic [55:0] r_den;
    logic [56:0] r_rem;
    logic [23:0] r_q;
    logic        r_scale_sat;
    logic        r_sat;
    logic [31:0] r_span;
    logic [31:0] r_new_lo;
    logic [55:0] r_prod;
    logic [23:0] r_scale_use;
    logic [4:0]  r_div_cnt;
    logic [CW-1:0] r_issue, r_nb_last, r_pend_j, r_k;
    logic        r_pend_v;

    logic [AW-1:0] rd_addr_old, rd_addr_scale, wr_addr;
    logic          idx0, k0;
    logic [31:0]   old_lo;
    logic [56:0]   rem2;
    logic [23:0]   scale_sel;
    logic [40:0]   rnd;
    logic [41:0]   sum;
    logic          ovf;
    logic [31:0]   value;
    logic [CW-1:0] nb_clamped;
    logic          issue_more;

    assign idx0 = (r_item.bin_index == 8'd0);
    assign k0   = (r_k == '0);
    assign wr_addr = AW'(r_item.bin_index);

    always_comb begin
        rd_addr_old   = AW'({1'b0, r_item.bin_index} - 9'd1);
        rd_addr_scale = r_k[AW-1:0];
        if (i_cmd.scan) begin
            rd_addr_old = r_issue[AW-1:0];
        end else if (i_cmd.map_rd) begin
            rd_addr_old = AW'(r_k - CW'(1));
        end
    end

    always_comb begin
        if (i_bins_in_use == 9'd0) begin
            nb_clamped = CW'(1);
        end else if (int'(i_bins_in_use) > BIN_DEPTH) begin
            nb_clamped = CW'(BIN_DEPTH);
        end else begin
            nb_clamped = CW'(i_bins_in_use);
        end
    end

    assign issue_more = (r_issue < r_nb_last);
    assign old_lo     = (i_cmd.map_lo ? k0 : idx0) ? 32'd0 : r_rd_old;
    assign rem2       = {r_rem[55:0], 1'b0};
    assign scale_sel  = r_scale_sat ? pltr_pkg::SCALE_MAX : r_q;
    assign rnd        = 41'(({1'b0, r_prod} + 57'h8000) >> 16);
    assign sum        = {10'd0, r_new_lo} + {1'b0, rnd};
    assign ovf        = (sum[41:32] != 10'd0);
    assign value      = ovf ? 32'hFFFFFFFF : sum[31:0];

    // Tables: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && (r_item.func == pltr_pkg::FUNC_LOAD)) begin
            mem_old[wr_addr]   <= r_item.upper_edge;
            mem_new[wr_addr]   <= value;
            mem_scale[wr_addr] <= scale_sel;
        end
        r_rd_old   <= mem_old[rd_addr_old];
        r_rd_new   <= mem_new[rd_addr_old];
        r_rd_scale <= mem_scale[rd_addr_scale];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.ld_rd) begin
            r_den <= i_theta * r_item.expected_len;
        end
        if (i_cmd.ld_chk) begin
            r_new_lo    <= idx0 ? 32'd0 : r_rd_new;
            r_span      <= (r_item.upper_edge < old_lo) ? 32'd0 : r_item.upper_edge - old_lo;
            // A quotient of 2^24 or more shows up as observed<<8 >= divisor.
            r_scale_sat <= ({16'd0, r_item.observed_len, 8'd0} >= r_den);
            r_sat       <= ({16'd0, r_item.observed_len, 8'd0} >= r_den)
                           || (r_item.upper_edge < old_lo);
            r_rem       <= {17'd0, r_item.observed_len, 8'd0};
            r_q         <= 24'd0;
        end
        if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= rem2 - {1'b0, r_den};
                r_q   <= {r_q[22:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_q   <= {r_q[22:0], 1'b0};
            end
        end
        if (i_cmd.map_lo) begin
            r_new_lo    <= k0 ? 32'd0 : r_rd_new;
            r_span      <= r_item.time_in - old_lo;
            r_q         <= r_rd_scale;
            r_scale_sat <= 1'b0;
            r_sat       <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod      <= r_span * scale_sel;
            r_scale_use <= scale_sel;
        end
        if (i_cmd.add) begin
            r_res <= '{value_out: value, scale_out: r_scale_use, saturated: r_sat | ovf};
        end else if (i_cmd.samp_res) begin
            r_res <= '{value_out: r_item.time_in, scale_out: pltr_pkg::SCALE_ONE,
                       saturated: 1'b0};
        end else if (i_cmd.zero_res) begin
            r_res <= '0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
        if (i_cmd.map_init) begin
            r_nb_last <= nb_clamped - CW'(1);
        end
        if (i_cmd.scan && issue_more) begin
            r_pend_j <= r_issue + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_issue   <= '0;
            r_pend_v  <= 1'b0;
            r_k       <= '0;
        end else begin
            if (i_cmd.ld_chk) begin
                r_div_cnt <= 5'd23;
            end else if (i_cmd.div_step && (r_div_cnt != 5'd0)) begin
                r_div_cnt <= r_div_cnt - 5'd1;
            end
            if (i_cmd.map_init) begin
                r_issue  <= '0;
                r_pend_v <= 1'b0;
                r_k      <= '0;
            end else if (i_cmd.scan) begin
                r_pend_v <= issue_more;
                if (issue_more) begin
                    r_issue <= r_issue + CW'(1);
                end
                // The latest qualifying lower edge wins, as in a linear scan.
                if (r_pend_v && (r_rd_old <= r_item.time_in)) begin
                    r_k <= r_pend_j;
                end
            end
        end
    end

    assign o_sts.func      = r_item.func;
    assign o_sts.passthru  = r_item.passthru;
    assign o_sts.oob       = (int'(r_item.bin_index) >= BIN_DEPTH);
    assign o_sts.div_done  = (r_div_cnt == 5'd0);
    assign o_sts.scan_done = !issue_more && !r_pend_v;
    assign o_out_item      = r_out;

endmodule
`default_nettype wire

/* hw/rtl/pltr_ctrl.sv */
// Controller of the rescaler: sequences load and map items through the datapath.
`default_nettype none
module pltr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    input  wire pltr_pkg::t_dp_sts i_sts,
    output pltr_pkg::t_dp_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LD_CHK, S_LD_DIV, S_SCAN, S_MAP_RD, S_MAP_LO,
        S_MUL, S_ADD, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.func == pltr_pkg::FUNC_LOAD) begin
                    if (i_sts.oob) begin
                        o_cmd.zero_res = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.ld_rd = 1'b1;
                        n_state     = S_LD_CHK;
                    end
                end else if (i_sts.passthru) begin
                    o_cmd.samp_res = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.map_init = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_LD_CHK: begin
                o_cmd.ld_chk = 1'b1;
                n_state      = S_LD_DIV;
            end
            S_LD_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_MAP_RD;
                end
            end
            S_MAP_RD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_MAP_LO;
            end
            S_MAP_LO: begin
                o_cmd.map_lo = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/piecewise_linear_time_rescaler_unit.sv */
// A load item is paced by the 24 steps of the bit-serial divider that forms
// observed / (theta * expected). A map item is paced by the scan of the stored
// lower edges, one edge per cycle through the read port of the edge table. One
// item is in work at a time; the next item is accepted while the previous
// result still waits in the output register. The bin tables hold no reset
// value: load a bin before any map item can reach it.
`default_nettype none
module piecewise_linear_time_rescaler_unit #(
    parameter int BIN_DEPTH = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire pltr_pkg::t_in_item i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output pltr_pkg::t_out_item  o_out_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [2:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [23:0] r_theta;
    logic [8:0]  r_bins;
    pltr_pkg::t_dp_cmd cmd;
    pltr_pkg::t_dp_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= pltr_pkg::THETA_RESET;
            r_bins  <= pltr_pkg::BINS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == pltr_pkg::REG_THETA) begin
                r_theta <= pwdata[23:0];
            end else begin
                r_bins <= pwdata[8:0];
            end
        end
    end

    assign prdata = (paddr[2] == pltr_pkg::REG_BINS) ? {23'd0, r_bins} : {8'd0, r_theta};

    pltr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pltr_datapath #(
        .BIN_DEPTH (BIN_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_item     (i_in_item),
        .i_theta       (r_theta),
        .i_bins_in_use (r_bins),
        .o_out_item    (o_out_item)
    );

endmodule
`default_nettype wire

/* tb/sv/piecewise_linear_time_rescaler_unit_test.sv */
// Self-checking testbench of the piecewise linear time rescaler unit.
`default_nettype none
module piecewise_linear_time_rescaler_unit_test;

    localparam int        NBINS        = 256;
    localparam int        CYCLE_LIMIT  = 1500000;
    localparam int        IN_BITS      = $bits(pltr_pkg::t_in_item);
    localparam logic [2:0] ADDR_THETA  = {pltr_pkg::REG_THETA, 2'b00};
    localparam logic [2:0] ADDR_BINS   = {pltr_pkg::REG_BINS, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    pltr_pkg::t_in_item  i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    pltr_pkg::t_out_item o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    piecewise_linear_time_rescaler_unit #(.BIN_DEPTH(NBINS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block's tables and registers.
    logic [23:0] theta_q;
    logic [8:0]  bins_q;
    logic [31:0] old_edge_tbl [NBINS];
    logic [31:0] new_edge_tbl [NBINS];
    logic [23:0] scale_tbl    [NBINS];

    pltr_pkg::t_out_item pending_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          quiet_sender = 0;
    bit          quiet_receiver = 0;
    int          hold_requests = 0;
    int          last_load = 0;

    function automatic logic [31:0] scaled_sum(input logic [31:0] base, input logic [31:0] span,
                                               input logic [23:0] scale, inout logic sat);
        logic [63:0] prod;
        logic [63:0] sum;
        prod = {32'd0, span} * {40'd0, scale};
        sum = {32'd0, base} + ((prod + 64'h8000) >> 16);
        if (sum > 64'hFFFFFFFF) begin
            sat = 1'b1;
            return 32'hFFFFFFFF;
        end
        return sum[31:0];
    endfunction

    function automatic pltr_pkg::t_out_item rescale(input pltr_pkg::t_in_item it);
        pltr_pkg::t_out_item r;
        logic [31:0] old_lo, new_lo, span;
        logic [63:0] den, quo;
        int          nb, k;
        r = '0;
        if (it.func == pltr_pkg::FUNC_LOAD) begin
            old_lo = (it.bin_index == 0) ? 32'd0 : old_edge_tbl[it.bin_index - 1];
            new_lo = (it.bin_index == 0) ? 32'd0 : new_edge_tbl[it.bin_index - 1];
            den = {40'd0, theta_q} * {32'd0, it.expected_len};
            if (den == 0) begin
                r.scale_out = pltr_pkg::SCALE_MAX;
                r.saturated = 1'b1;
            end else begin
                quo = {it.observed_len, 32'd0} / den;
                if (quo > {40'd0, pltr_pkg::SCALE_MAX}) begin
                    r.scale_out = pltr_pkg::SCALE_MAX;
                    r.saturated = 1'b1;
                end else begin
                    r.scale_out = quo[23:0];
                end
            end
            if (it.upper_edge < old_lo) begin
                span = 32'd0;
                r.saturated = 1'b1;
            end else begin
                span = it.upper_edge - old_lo;
            end
            r.value_out = scaled_sum(new_lo, span, r.scale_out, r.saturated);
            old_edge_tbl[it.bin_index] = it.upper_edge;
            new_edge_tbl[it.bin_index] = r.value_out;
            scale_tbl[it.bin_index] = r.scale_out;
        end else if (it.passthru) begin
            r.value_out = it.time_in;
            r.scale_out = pltr_pkg::SCALE_ONE;
        end else begin
            nb = (bins_q < 1) ? 1 : (bins_q > NBINS) ? NBINS : int'(bins_q);
            k = 0;
            for (int j = 1; j < nb; j++)
                if (old_edge_tbl[j - 1] <= it.time_in) k = j;
            old_lo = (k == 0) ? 32'd0 : old_edge_tbl[k - 1];
            new_lo = (k == 0) ? 32'd0 : new_edge_tbl[k - 1];
            r.scale_out = scale_tbl[k];
            r.value_out = scaled_sum(new_lo, it.time_in - old_lo, r.scale_out, r.saturated);
        end
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_THETA) theta_q = data[23:0];
        else bins_q = data[8:0];
        @(posedge i_clk);
    endtask

    // Offers one item, waits for it to be taken, then maybe idles.
    task automatic send_item(input pltr_pkg::t_in_item it, input bit has_fixed,
                             input pltr_pkg::t_out_item fixed);
        pltr_pkg::t_out_item pred;
        pred = rescale(it);
        pending_results.push_back(has_fixed ? fixed : pred);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (!quiet_sender && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] ratio_len(input logic [31:0] e);
        logic [31:0] o;
        o = e >> $urandom_range(0, 3);
        o = o << $urandom_range(0, 3);
        return o + $urandom_range(0, 255);
    endfunction

    function automatic pltr_pkg::t_in_item random_item;
        pltr_pkg::t_in_item it;
        int       r;
        int       k;
        it = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 25) begin
            it.func = pltr_pkg::FUNC_LOAD;
            if ($urandom_range(0, 1)) it.bin_index = 8'(last_load + 1);
            last_load = int'(it.bin_index);
            if ($urandom_range(0, 9) != 0)
                it.upper_edge = ((it.bin_index == 0) ? 32'd0 : old_edge_tbl[it.bin_index - 1])
                                + $urandom_range(0, 32'h0010_0000);
            it.expected_len = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 19) == 0) it.expected_len = 32'd0;
            if ($urandom_range(0, 9) != 0) it.observed_len = ratio_len(it.expected_len);
        end else begin
            it.func = pltr_pkg::FUNC_MAP;
            it.passthru = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 1)) begin
                k = $urandom_range(0, NBINS - 1);
                it.time_in = old_edge_tbl[k] + $urandom_range(0, 8) - 4;
            end else begin
                it.time_in = $urandom >> $urandom_range(0, 4);
            end
        end
        return it;
    endfunction

    // Result checking against the oldest expectation.
    always @(posedge i_clk) begin
        pltr_pkg::t_out_item want;
        if (o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected item %h", o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.value_out !== want.value_out
                        || o_out_item.scale_out !== want.scale_out
                        || o_out_item.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d value %h/%h scale %h/%h sat %b/%b (exp/got)",
                                 results_seen, want.value_out, o_out_item.value_out,
                                 want.scale_out, o_out_item.scale_out,
                                 want.saturated, o_out_item.saturated);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        int hold_left;
        int hold_seen;
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_receiver && ($urandom_range(0, 99) < 12);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    typedef struct {
        pltr_pkg::t_in_item  item;
        bit                  has_fixed;
        pltr_pkg::t_out_item fixed;
    } t_row;

    function automatic pltr_pkg::t_in_item mk(input logic f, input logic [7:0] idx,
                                              input logic [31:0] up, input logic [31:0] obs,
                                              input logic [31:0] ex, input logic [31:0] tm,
                                              input logic smp);
        pltr_pkg::t_in_item it;
        it = '{f, idx, up, obs, ex, tm, smp};
        return it;
    endfunction

    initial begin
        t_row        rows [$];
        logic [31:0] edge_acc;
        pltr_pkg::t_in_item it;
        int          theta_set [6];
        int          bins_set  [6];
        int          count_set [6];

        // The shadow tables start at zero so that random times stay defined.
        foreach (old_edge_tbl[i]) begin
            old_edge_tbl[i] = '0;
            new_edge_tbl[i] = '0;
            scale_tbl[i]    = '0;
        end

        // Directed rows run with four bins in use; only bins 0..3 are ever read.
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 0, 32'h1000, 32'h1000, 32'h1000, 0, 0), 1,
                         '{32'h1000, pltr_pkg::SCALE_ONE, 1'b0}});
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 1, 32'h3000, 32'h5, 32'h0, 0, 1), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 2, 32'h0, 32'h2000, 32'h1000, 0, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 0, 0),
                         1, '{32'hFFFFFFFF, pltr_pkg::SCALE_MAX, 1'b1}});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h0, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h800, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h1000, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h2FFF, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'hFFFFFFFF, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                            32'hFFFFFFFF, 1), 1, '{32'hFFFFFFFF, pltr_pkg::SCALE_ONE, 1'b0}});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h0, 1), 1,
                         '{32'h0, pltr_pkg::SCALE_ONE, 1'b0}});
        // Out of order: reload bin 1 after bin 3, then a non-ascending search.
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 1, 32'h4000, 32'h3000, 32'h1000, 0, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 0, 32'h0, 32'h0, 32'hFFFFFFFF, 0, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h3800, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h8000_0000, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 2, 32'h5000, 32'h0, 32'h1000, 0, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_LOAD, 3, 32'h6000, 32'h1000, 32'h1000, 0, 0), 0, '0});
        rows.push_back('{mk(pltr_pkg::FUNC_MAP, 0, 0, 0, 0, 32'h5800, 0), 0, '0});

        theta_q = pltr_pkg::THETA_RESET;
        bins_q = pltr_pkg::BINS_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_write(ADDR_THETA, 32'h10000);
        reg_write(ADDR_BINS, 32'd4);
        foreach (rows[i]) send_item(rows[i].item, rows[i].has_fixed, rows[i].fixed);
        drain();

        // Theta at its smallest and a bin count of zero, which is clamped to one.
        reg_write(ADDR_THETA, 32'd1);
        reg_write(ADDR_BINS, 32'd0);
        for (int i = 0; i < 20; i++) begin
            it = random_item();
            if (it.func == pltr_pkg::FUNC_LOAD) it.bin_index = 8'($urandom_range(1, 3));
            send_item(it, 0, '0);
        end
        drain();

        // Load the whole table in ascending order so that every entry is written.
        reg_write(ADDR_THETA, 32'h10000);
        quiet_sender = 1;
        quiet_receiver = 1;
        edge_acc = 0;
        for (int b = 0; b < NBINS; b++) begin
            it = random_item();
            it.func = pltr_pkg::FUNC_LOAD;
            it.bin_index = 8'(b);
            edge_acc = edge_acc + $urandom_range(1, 32'h0010_0000);
            it.upper_edge = edge_acc;
            it.expected_len = $urandom_range(32'h100, 32'hFFFFFF);
            it.observed_len = ratio_len(it.expected_len);
            send_item(it, 0, '0);
        end
        drain();
        quiet_sender = 0;
        quiet_receiver = 0;

        theta_set = '{32'h10000, 32'hFFFFFF, 32'h10000, 32'd1, 32'h8000, 32'h10000};
        bins_set  = '{256, 8, 511, 64, 1, 0};
        count_set = '{200, 150, 80, 200, 150, 150};
        theta_set[4] = $urandom_range(1, 32'hFFFFFF);
        bins_set[3] = $urandom_range(2, 256);
        for (int p = 0; p < 6; p++) begin
            reg_write(ADDR_THETA, theta_set[p]);
            reg_write(ADDR_BINS, bins_set[p]);
            if (p == 3) hold_requests++;
            quiet_sender = (p == 4);
            for (int i = 0; i < count_set[p]; i++) send_item(random_item(), 0, '0);
            // The sender pauses here until every expected item has come back.
            drain();
        end
        quiet_sender = 0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Covered %0d items and %0d results over loads, maps and samples,",
                 items_sent, results_seen);
        $display("with theta and bin count at their extremes; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
